[hdl/bfiq_pkg.sv]
// Package for the bloom filter insert/query unit.
// Sizes of the bit store, hash words and probe limits. No dependencies.
package bfiq_pkg;

  localparam int FILTER_BITS = 65536;
  localparam int MAX_HASHES  = 16;

  localparam int ADDR_W  = $clog2(FILTER_BITS);
  localparam int SIZE_W  = ADDR_W + 1;
  localparam int HASH_W  = 64;
  localparam int DCNT_W  = $clog2(HASH_W);
  localparam int FSIZE_W = 17;
  localparam int HCNT_W  = 5;

  localparam logic [HASH_W-1:0] DJB2_START = HASH_W'(5381);

  localparam logic [FSIZE_W-1:0] FSIZE_RESET = FSIZE_W'(65536);
  localparam logic [HCNT_W-1:0]  HCNT_RESET  = HCNT_W'(3);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT  = CFG_IDX_W'(1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

endpackage

[hdl/bloom_filter_insert_query_unit.sv]
// Bloom filter insert/query unit: byte stream hashing, modulo reduction, bit store.
// Depends on bfiq_pkg.

// Words arrive one byte per transfer; each byte is folded into the djb2 and
// sdbm hashes as it is taken. On the byte with tlast, one shared restoring
// divider reduces djb2 then sdbm modulo the clamped filter_size, one bit per
// cycle, followed by a setup state (ST_PREP), then the probe loop: an insert
// writes one bit in ST_PROBE per probe, a query reads it in ST_PROBE and
// tests it in ST_CHECK (single-port bit store with registered read) and stops
// at the first clear bit. A last pass through ST_PROBE closes the probe loop
// and ST_DONE finishes; the number of probes k is the clamped hash_count. A
// query result waits in ST_DONE while an earlier result has not been taken.
// After reset the bit store is cleared one bit per cycle over all FILTER_BITS
// (65536) bits, during which no byte is taken; configuration writes are taken
// at any time. Only queries produce a result.
module bloom_filter_insert_query_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] byte_value
  input  logic                              s_axis_tuser,   // [0] command
  input  logic                              s_axis_tlast,   // word_end
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,   // [0] is_member, rest zero
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bfiq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfiq_pkg::FSIZE_W-1:0]      cfg_data
);
  import bfiq_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_PREP  = 3'd3;
  localparam logic [2:0] ST_PROBE = 3'd4;
  localparam logic [2:0] ST_CHECK = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]          state;
  logic [FSIZE_W-1:0]  filter_size;
  logic [HCNT_W-1:0]   hash_count;
  logic [HASH_W-1:0]   djb2;
  logic [HASH_W-1:0]   sdbm;
  logic [HASH_W-1:0]   djb2_next;
  logic [HASH_W-1:0]   sdbm_next;
  logic                cmd;
  logic [SIZE_W-1:0]   size;
  logic [HCNT_W-1:0]   k;
  logic [DCNT_W-1:0]   dcnt;
  logic                div_sel;
  logic [ADDR_W-1:0]   rem;
  logic [ADDR_W-1:0]   rem_next;
  logic [SIZE_W-1:0]   rem_shift;
  logic [ADDR_W-1:0]   first;
  logic [ADDR_W-1:0]   second;
  logic [ADDR_W-1:0]   second2;
  logic [ADDR_W-1:0]   term;
  logic [ADDR_W-1:0]   delta;
  logic [HCNT_W-1:0]   y;
  logic                member;
  logic [ADDR_W-1:0]   clr_addr;
  logic [ADDR_W-1:0]   probe_idx;
  logic                in_fire;
  logic [SIZE_W-1:0]   size_used;
  logic [HCNT_W-1:0]   k_used;

  logic                mem [FILTER_BITS];
  logic                mem_we;
  logic                mem_wdata;
  logic [ADDR_W-1:0]   mem_addr;
  logic                mem_rdata;

  function automatic logic [ADDR_W-1:0] mod_add(input logic [ADDR_W-1:0] a,
                                                input logic [ADDR_W-1:0] b,
                                                input logic [SIZE_W-1:0] m);
    logic [SIZE_W-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= m) begin
      s = s - m;
    end
    return s[ADDR_W-1:0];
  endfunction

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign djb2_next = (djb2 << 5) + djb2 + {{(HASH_W-8){1'b0}}, s_axis_tdata};
  assign sdbm_next = {{(HASH_W-8){1'b0}}, s_axis_tdata} + (sdbm << 6) + (sdbm << 16) - sdbm;

  always_comb begin
    size_used = SIZE_W'(filter_size);
    if (filter_size == '0) begin
      size_used = SIZE_W'(1);
    end else if (32'(filter_size) > FILTER_BITS) begin
      size_used = SIZE_W'(FILTER_BITS);
    end
    k_used = hash_count;
    if (32'(hash_count) > MAX_HASHES) begin
      k_used = HCNT_W'(MAX_HASHES);
    end
  end

  // one step of the shared restoring divider
  always_comb begin
    rem_shift = {rem, (div_sel ? sdbm[HASH_W-1] : djb2[HASH_W-1])};
    if (rem_shift >= size) begin
      rem_shift = rem_shift - size;
    end
    rem_next = rem_shift[ADDR_W-1:0];
  end

  assign probe_idx = mod_add(first, term, size);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = 1'b0;
    mem_addr  = probe_idx;
    if (state == ST_CLEAR) begin
      mem_we   = 1'b1;
      mem_addr = clr_addr;
    end else if (state == ST_PROBE && y != k && cmd == CMD_INSERT) begin
      mem_we    = 1'b1;
      mem_wdata = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_size   <= FSIZE_RESET;
      hash_count    <= HCNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FILTER_SIZE: filter_size <= cfg_data;
        REG_HASH_COUNT:  hash_count  <= cfg_data[HCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      djb2          <= DJB2_START;
      sdbm          <= '0;
      m_axis_tvalid <= 1'b0;
      dcnt          <= '0;
      div_sel       <= 1'b0;
      rem           <= '0;
      y             <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready &&
          !(state == ST_DONE && cmd == CMD_QUERY)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(FILTER_BITS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            djb2 <= djb2_next;
            sdbm <= sdbm_next;
            if (s_axis_tlast) begin
              cmd     <= s_axis_tuser;
              size    <= size_used;
              k       <= k_used;
              dcnt    <= '0;
              div_sel <= 1'b0;
              rem     <= '0;
              state   <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          dcnt <= dcnt + DCNT_W'(1);
          if (div_sel) begin
            sdbm <= sdbm << 1;
          end else begin
            djb2 <= djb2 << 1;
          end
          if (dcnt == DCNT_W'(HASH_W - 1)) begin
            rem <= '0;
            if (div_sel) begin
              second <= rem_next;
              state  <= ST_PREP;
            end else begin
              first   <= rem_next;
              div_sel <= 1'b1;
            end
          end else begin
            rem <= rem_next;
          end
        end
        ST_PREP: begin
          second2 <= mod_add(second, second, size);
          delta   <= second;
          term    <= '0;
          y       <= '0;
          member  <= 1'b1;
          djb2    <= DJB2_START;
          sdbm    <= '0;
          state   <= ST_PROBE;
        end
        ST_PROBE: begin
          if (y == k) begin
            state <= ST_DONE;
          end else begin
            // y^2*s advances by (2y+1)*s, which advances by 2s
            term  <= mod_add(term, delta, size);
            delta <= mod_add(delta, second2, size);
            y     <= y + HCNT_W'(1);
            if (cmd == CMD_QUERY) begin
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (!mem_rdata) begin
            member <= 1'b0;
            state  <= ST_DONE;
          end else begin
            state <= ST_PROBE;
          end
        end
        ST_DONE: begin
          if (cmd == CMD_INSERT) begin
            state <= ST_IDLE;
          end else if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {7'b0, member};
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
